// ===== rtl/thw_pkg.sv =====
// ----------------------------------------------------------------------------
// thw_pkg
// Shared types and constants of the tar header walker: block geometry,
// header field offsets, walk phase codes, the result record and the magic characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package thw_pkg;

    localparam int BLOCK_BYTES  = 512;
    localparam int POS_W        = $clog2(BLOCK_BYTES);
    localparam int SIZE_DIGITS  = 12;
    localparam int SIZE_START   = 124;
    localparam int MAGIC_START  = 257;
    localparam int MAGIC_LEN    = 5;

    localparam int BYTE_W       = 8;
    localparam int BLOCK_W      = 24;
    localparam int FSIZE_W      = 36;
    localparam int NBLK_W       = 28;

    localparam logic [BLOCK_W-1:0] LIMIT_RESET = {BLOCK_W{1'b1}};
    localparam logic [BYTE_W-1:0]  CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0]  CHAR_SEVEN  = 8'h37;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_SKIP   = 3'b010,
        PH_STOP   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [BLOCK_W-1:0] header_block;
        logic [FSIZE_W-1:0] file_size;
        logic [NBLK_W-1:0]  data_blocks;
        logic               end_of_archive;
    } t_result;

    // Expected magic character at a given offset within the magic field.
    function automatic logic [BYTE_W-1:0] magic_char(input logic [2:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            3'd0:    c = 8'h75;  // u
            3'd1:    c = 8'h73;  // s
            3'd2:    c = 8'h74;  // t
            3'd3:    c = 8'h61;  // a
            3'd4:    c = 8'h72;  // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/tar_header_walker.sv =====
// ----------------------------------------------------------------------------
// tar_header_walker
// Walks a USTAR archive one byte per request, checks header magic, parses the
// octal size field and reports each header with its data block count, or an
// end-of-archive result on bad magic. An accepted byte waits in the input
// register; its result enters the output slot, or the skid slot while the
// output slot is held. Throughput: one byte per cycle unless the skid is full.
// Reset (synchronous, active low) clears the walk state, empties both output
// slots and sets block_limit to 16777215.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tar_header_walker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [thw_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_restart,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [thw_pkg::BLOCK_W-1:0]   o_header_block,
    output logic [thw_pkg::FSIZE_W-1:0]   o_file_size,
    output logic [thw_pkg::NBLK_W-1:0]    o_data_blocks,
    output logic                          o_end_of_archive,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [thw_pkg::BLOCK_W-1:0]   i_cfg_data
);

    import thw_pkg::*;

    // input register
    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;
    logic                 r_in_restart;

    // walk state
    logic [BLOCK_W-1:0]   r_block_limit;
    logic [POS_W-1:0]     r_byte_in_block, n_byte_in_block;
    logic [BLOCK_W-1:0]   r_block_index,   n_block_index;
    logic [NBLK_W-1:0]    r_blocks_to_skip, n_blocks_to_skip;
    logic [FSIZE_W-1:0]   r_size_accum,    n_size_accum;
    logic                 r_magic_ok,      n_magic_ok;
    t_phase               r_phase,         n_phase;

    // result slots
    logic                 r_out_valid;
    t_result              r_out;
    logic                 r_skid_valid;
    t_result              r_skid;

    logic                 in_accept;
    logic                 proc;
    logic                 take;
    logic                 res_valid;
    t_result              res;

    // effective state after an optional restart
    logic [POS_W-1:0]     e_pos;
    logic [BLOCK_W-1:0]   e_index;
    logic [NBLK_W-1:0]    e_skip;
    logic [FSIZE_W-1:0]   e_accum;
    logic                 e_magic_ok;
    t_phase               e_phase;

    logic                 active;
    logic                 last;
    logic [POS_W-1:0]     magic_off;
    logic [FSIZE_W:0]     round_sum;
    logic [NBLK_W-1:0]    nblk;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_in_valid & r_skid_valid;
    assign in_accept   = i_valid & ~o_stall;
    assign proc        = r_in_valid & ~r_skid_valid;
    assign take        = r_out_valid & ~i_stall;

    assign o_valid          = r_out_valid;
    assign o_header_block   = r_out.header_block;
    assign o_file_size      = r_out.file_size;
    assign o_data_blocks    = r_out.data_blocks;
    assign o_end_of_archive = r_out.end_of_archive;

    always_comb begin
        e_pos      = r_in_restart ? '0 : r_byte_in_block;
        e_index    = r_in_restart ? '0 : r_block_index;
        e_skip     = r_in_restart ? '0 : r_blocks_to_skip;
        e_accum    = r_in_restart ? '0 : r_size_accum;
        e_magic_ok = r_in_restart ? 1'b1 : r_magic_ok;
        e_phase    = r_in_restart ? PH_HEADER : r_phase;

        active    = ((e_phase == PH_HEADER) || (e_phase == PH_SKIP)) &&
                    (e_index < r_block_limit);
        last      = (e_pos == POS_W'(BLOCK_BYTES - 1));
        magic_off = e_pos - POS_W'(MAGIC_START);

        n_byte_in_block  = r_byte_in_block;
        n_block_index    = r_block_index;
        n_blocks_to_skip = r_blocks_to_skip;
        n_size_accum     = r_size_accum;
        n_magic_ok       = r_magic_ok;
        n_phase          = r_phase;
        res_valid        = 1'b0;
        res              = '0;

        // round the size up to whole blocks
        round_sum = {1'b0, e_accum} + (FSIZE_W+1)'(BLOCK_BYTES - 1);
        nblk      = round_sum[POS_W +: NBLK_W];

        if (proc) begin
            n_byte_in_block  = e_pos;
            n_block_index    = e_index;
            n_blocks_to_skip = e_skip;
            n_size_accum     = e_accum;
            n_magic_ok       = e_magic_ok;
            n_phase          = e_phase;

            if (active) begin
                if (e_phase == PH_HEADER) begin
                    if ((e_pos >= POS_W'(MAGIC_START)) &&
                        (e_pos < POS_W'(MAGIC_START + MAGIC_LEN)) &&
                        (r_in_byte != magic_char(magic_off[2:0]))) begin
                        n_magic_ok = 1'b0;
                    end
                    if ((e_pos >= POS_W'(SIZE_START)) &&
                        (e_pos < POS_W'(SIZE_START + SIZE_DIGITS)) &&
                        (r_in_byte >= CHAR_ZERO) && (r_in_byte <= CHAR_SEVEN)) begin
                        n_size_accum = {e_accum[FSIZE_W-4:0], r_in_byte[2:0]};
                    end
                    if (last) begin
                        res_valid = 1'b1;
                        if (e_magic_ok) begin
                            res.header_block   = e_index;
                            res.file_size      = e_accum;
                            res.data_blocks    = nblk;
                            res.end_of_archive = 1'b0;
                            n_blocks_to_skip   = nblk;
                            n_phase            = (nblk != '0) ? PH_SKIP : PH_HEADER;
                        end else begin
                            res.end_of_archive = 1'b1;
                            n_phase            = PH_STOP;
                        end
                        n_size_accum = '0;
                        n_magic_ok   = 1'b1;
                    end
                end else if (last) begin
                    if (e_skip != '0) begin
                        n_blocks_to_skip = e_skip - NBLK_W'(1);
                    end
                    if (n_blocks_to_skip == '0) begin
                        n_phase = PH_HEADER;
                    end
                end

                if (last) begin
                    n_byte_in_block = '0;
                    n_block_index   = e_index + BLOCK_W'(1);
                end else begin
                    n_byte_in_block = e_pos + POS_W'(1);
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_block_limit    <= LIMIT_RESET;
            r_byte_in_block  <= '0;
            r_block_index    <= '0;
            r_blocks_to_skip <= '0;
            r_size_accum     <= '0;
            r_magic_ok       <= 1'b1;
            r_phase          <= PH_HEADER;
            r_out_valid      <= 1'b0;
            r_skid_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_block_limit <= i_cfg_data;
            end
            r_byte_in_block  <= n_byte_in_block;
            r_block_index    <= n_block_index;
            r_blocks_to_skip <= n_blocks_to_skip;
            r_size_accum     <= n_size_accum;
            r_magic_ok       <= n_magic_ok;
            r_phase          <= n_phase;

            // the skid slot only fills while the output slot is held
            if (take) begin
                r_out_valid  <= r_skid_valid | res_valid;
                r_skid_valid <= 1'b0;
            end else if (!r_out_valid) begin
                r_out_valid <= res_valid;
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte    <= i_data_byte;
            r_in_restart <= i_restart;
        end
        if (take) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (!r_out_valid) begin
            r_out <= res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a result while output slot is empty");

    a_skip_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_blocks_to_skip != '0))
        else $error("skipping data with no blocks left to skip");

    a_eoa_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.end_of_archive) |->
            (r_out.header_block == '0 && r_out.file_size == '0 &&
             r_out.data_blocks == '0))
        else $error("end of archive result carries nonzero fields");

    a_stop_after_eoa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.end_of_archive) |=> (r_phase == PH_STOP))
        else $error("walk did not stop after end of archive");

endmodule
